FILE: sv/mmq_pkg.sv
// Shared definitions for the monotonic minimum queue.
// Holds field widths, output packing offsets, request kinds, status codes and the FSM type.
// No dependencies.
`timescale 1ns / 1ps

package mmq_pkg;

  // Field widths of the request and result items.
  localparam int VALUE_W       = 32;
  localparam int STORE_COUNT_W = 7;
  localparam int MIN_POS_W     = 6;
  localparam int QUEUE_COUNT_W = 7;
  localparam int STATUS_W      = 2;

  // Result tdata layout, lowest bit first.
  localparam int OUT_SC_LSB  = 0;
  localparam int OUT_POS_LSB = OUT_SC_LSB + STORE_COUNT_W;
  localparam int OUT_MIN_LSB = OUT_POS_LSB + MIN_POS_W;
  localparam int OUT_QC_LSB  = OUT_MIN_LSB + VALUE_W;
  localparam int OUT_ST_LSB  = OUT_QC_LSB + QUEUE_COUNT_W;
  localparam int OUT_USED_W  = OUT_ST_LSB + STATUS_W;
  localparam int OUT_DATA_W  = ((OUT_USED_W + 7) / 8) * 8;

  // Request kinds carried on in_tuser.
  localparam logic KIND_ENQ = 1'b0;
  localparam logic KIND_DEQ = 1'b1;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_DEQ_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ENQ_FULL  = 2'd2;

  // Control sequencer states, one-hot.
  typedef enum logic [3:0] {
    S_IDLE    = 4'b0001,
    S_ENQ_CMP = 4'b0010,
    S_DEQ_LD  = 4'b0100,
    S_FIN     = 4'b1000
  } state_t;

endpackage

FILE: sv/mmq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Used for the deque storage of the monotonic minimum queue.
// No dependencies.
`timescale 1ns / 1ps

module mmq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/monotonic_min_queue.sv
// Top level of the monotonic minimum queue: control sequencer and result register.
// Depends on mmq_pkg and mmq_ram.
`timescale 1ns / 1ps

// A FIFO of up to DEPTH 32-bit values that reports its running minimum.
// Requests arrive on the in_ channel: in_tuser selects enqueue (0) or
// dequeue (1), in_tdata carries the value to enqueue. Every request gives
// exactly one result on the out_ channel with the deque size, the position
// of the minimum from the queue front, the minimum, the queue size and a
// status (dequeue from empty and enqueue when full change nothing).
// The minimum lives in a monotonic deque of (value, sequence) pairs held in
// one RAM with a registered read; the deque front is cached in registers.
// Rejected requests, enqueues into an empty deque and dequeues that keep
// the front go from acceptance straight to the finish state. Any other
// enqueue removes each larger entry from the deque back (each removal costs
// one RAM read and compare), then appends, or takes the freed slot as the
// front when it removes every entry; a dequeue that drops the front reads
// the next front from RAM if one is left. Items are processed one at a
// time; the next request is taken while an earlier result still waits in
// the output register. When the receiver stalls, the finished result of the
// following request waits until the output register frees. After reset the
// queue and the deque are empty and a request is taken in the first cycle.

module monotonic_min_queue #(
  parameter int DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // Request channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] kind
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  // [6:0] store_count, [12:7] min_position, [44:13] min_value,
  // [51:45] queue_count, [53:52] status, [55:54] zero
  output logic [mmq_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int SW   = $clog2(2 * DEPTH);
  localparam int CW   = $clog2(DEPTH + 1);
  localparam int VW   = mmq_pkg::VALUE_W;
  localparam int EW   = VW + SW;
  localparam int SCW  = mmq_pkg::STORE_COUNT_W;
  localparam int PW   = mmq_pkg::MIN_POS_W;
  localparam int QCW  = mmq_pkg::QUEUE_COUNT_W;
  localparam int STW  = mmq_pkg::STATUS_W;
  localparam int ODW  = mmq_pkg::OUT_DATA_W;
  localparam int PADW = ODW - mmq_pkg::OUT_USED_W;

  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [SW-1:0] LAST_SEQ  = SW'(2 * DEPTH - 1);
  localparam logic [SW:0]   SEQ_MOD   = (SW + 1)'(2 * DEPTH);
  localparam logic [CW-1:0] FULL_CNT  = CW'(DEPTH);

  // Control state.
  mmq_pkg::state_t state_r, state_nxt;
  logic [AW-1:0]   head_r, head_nxt;
  logic [AW-1:0]   tail_r, tail_nxt;
  logic [CW-1:0]   mcnt_r, mcnt_nxt;
  logic [CW-1:0]   icnt_r, icnt_nxt;
  logic [SW-1:0]   fseq_r, fseq_nxt;
  logic            ovld_r, ovld_nxt;

  // Payload registers.
  logic [VW-1:0]   hval_r, hval_nxt;
  logic [SW-1:0]   hseq_r, hseq_nxt;
  logic [VW-1:0]   val_r, val_nxt;
  logic [STW-1:0]  st_r, st_nxt;
  logic [ODW-1:0]  odata_r, odata_nxt;

  // RAM port signals.
  logic            ram_we;
  logic [AW-1:0]   ram_waddr;
  logic [EW-1:0]   ram_wdata;
  logic [AW-1:0]   ram_raddr;
  logic [EW-1:0]   ram_rdata;
  logic [VW-1:0]   rd_val;
  logic [SW-1:0]   rd_seq;

  // Derived pointers and sequence numbers.
  logic [AW-1:0]   head_p1, tail_m1, tail_m2;
  logic [SW-1:0]   fseq_p1, new_seq;
  logic [SW:0]     seq_sum;
  logic [SW:0]     pos_diff;
  logic [SW-1:0]   pos_full;
  logic            accept, out_free, has_min;
  logic [PW-1:0]   res_pos;
  logic [VW-1:0]   res_min;

  assign accept   = in_tvalid && in_tready;
  assign in_tready = (state_r == mmq_pkg::S_IDLE);
  assign out_free = !ovld_r || out_tready;

  assign rd_val = ram_rdata[VW-1:0];
  assign rd_seq = ram_rdata[EW-1:VW];

  // Circular slot arithmetic for the deque storage.
  assign head_p1 = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign tail_m1 = (tail_r == '0) ? LAST_SLOT : tail_r - 1'b1;
  assign tail_m2 = (tail_m1 == '0) ? LAST_SLOT : tail_m1 - 1'b1;

  // Sequence numbers count modulo twice the depth.
  assign fseq_p1 = (fseq_r == LAST_SEQ) ? '0 : fseq_r + 1'b1;
  assign seq_sum = {1'b0, fseq_r} + (SW + 1)'(icnt_r);
  assign new_seq = (seq_sum >= SEQ_MOD) ? SW'(seq_sum - SEQ_MOD) : SW'(seq_sum);

  // Position of the minimum from the queue front.
  assign pos_diff = {1'b0, hseq_r} - {1'b0, fseq_r};
  assign pos_full = pos_diff[SW] ? SW'(pos_diff + SEQ_MOD) : SW'(pos_diff);
  assign has_min  = (mcnt_r != '0) && (icnt_r != '0);
  assign res_pos  = has_min ? PW'(pos_full) : '0;
  assign res_min  = has_min ? hval_r : '0;

  // Sequencer: reads, compares and writes back the deque storage.
  always_comb begin
    state_nxt = state_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    mcnt_nxt  = mcnt_r;
    icnt_nxt  = icnt_r;
    fseq_nxt  = fseq_r;
    hval_nxt  = hval_r;
    hseq_nxt  = hseq_r;
    val_nxt   = val_r;
    st_nxt    = st_r;
    ram_we    = 1'b0;
    ram_waddr = tail_r;
    ram_wdata = {new_seq, val_r};
    ram_raddr = tail_m1;

    unique case (state_r)
      mmq_pkg::S_IDLE: begin
        if (accept) begin
          val_nxt   = in_tdata;
          st_nxt    = mmq_pkg::ST_OK;
          state_nxt = mmq_pkg::S_FIN;
          if (in_tuser == mmq_pkg::KIND_ENQ) begin
            if (icnt_r == FULL_CNT) begin
              st_nxt = mmq_pkg::ST_ENQ_FULL;
            end else if (mcnt_r == '0) begin
              // Empty deque: the new value becomes the front at once.
              ram_we    = 1'b1;
              ram_wdata = {new_seq, in_tdata};
              tail_nxt  = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
              mcnt_nxt  = mcnt_r + 1'b1;
              icnt_nxt  = icnt_r + 1'b1;
              hval_nxt  = in_tdata;
              hseq_nxt  = new_seq;
            end else begin
              // Read the back entry for the first compare.
              ram_raddr = tail_m1;
              state_nxt = mmq_pkg::S_ENQ_CMP;
            end
          end else begin
            if (icnt_r == '0) begin
              st_nxt = mmq_pkg::ST_DEQ_EMPTY;
            end else begin
              fseq_nxt = fseq_p1;
              icnt_nxt = icnt_r - 1'b1;
              if ((mcnt_r != '0) && (hseq_r == fseq_r)) begin
                // The departing item is the deque front: drop it.
                head_nxt  = head_p1;
                mcnt_nxt  = mcnt_r - 1'b1;
                ram_raddr = head_p1;
                if (mcnt_r != CW'(1)) begin
                  state_nxt = mmq_pkg::S_DEQ_LD;
                end
              end
            end
          end
        end
      end

      mmq_pkg::S_ENQ_CMP: begin
        if (rd_val > val_r) begin
          // Back entry is larger: remove it.
          mcnt_nxt = mcnt_r - 1'b1;
          tail_nxt = tail_m1;
          if (mcnt_r == CW'(1)) begin
            // Deque drained: the new value takes the freed slot as the front.
            ram_we    = 1'b1;
            ram_waddr = tail_m1;
            tail_nxt  = tail_r;
            mcnt_nxt  = CW'(1);
            icnt_nxt  = icnt_r + 1'b1;
            hval_nxt  = val_r;
            hseq_nxt  = new_seq;
            state_nxt = mmq_pkg::S_FIN;
          end else begin
            ram_raddr = tail_m2;
          end
        end else begin
          // Append after the surviving back entry.
          ram_we    = 1'b1;
          ram_waddr = tail_r;
          tail_nxt  = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
          mcnt_nxt  = mcnt_r + 1'b1;
          icnt_nxt  = icnt_r + 1'b1;
          state_nxt = mmq_pkg::S_FIN;
        end
      end

      mmq_pkg::S_DEQ_LD: begin
        // Load the new deque front into the cache.
        hval_nxt  = rd_val;
        hseq_nxt  = rd_seq;
        state_nxt = mmq_pkg::S_FIN;
      end

      mmq_pkg::S_FIN: begin
        if (out_free) begin
          state_nxt = mmq_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = mmq_pkg::S_IDLE;
      end
    endcase
  end

  // Result register.
  always_comb begin
    ovld_nxt  = ovld_r && !out_tready;
    odata_nxt = odata_r;
    if ((state_r == mmq_pkg::S_FIN) && out_free) begin
      ovld_nxt  = 1'b1;
      odata_nxt = {PADW'(0), st_r, QCW'(icnt_r), res_min, res_pos, SCW'(mcnt_r)};
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mmq_pkg::S_IDLE;
      head_r  <= '0;
      tail_r  <= '0;
      mcnt_r  <= '0;
      icnt_r  <= '0;
      fseq_r  <= '0;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      mcnt_r  <= mcnt_nxt;
      icnt_r  <= icnt_nxt;
      fseq_r  <= fseq_nxt;
      ovld_r  <= ovld_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    hval_r  <= hval_nxt;
    hseq_r  <= hseq_nxt;
    val_r   <= val_nxt;
    st_r    <= st_nxt;
    odata_r <= odata_nxt;
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = odata_r;

  // Deque storage: {sequence, value} per slot.
  mmq_ram #(
    .WIDTH (EW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: sv/mmq_checker.sv
// Port-level checks for the monotonic minimum queue, bound to the top level.
// Depends on mmq_pkg and monotonic_min_queue.
`timescale 1ns / 1ps

module mmq_checker #(
  parameter int DEPTH = 64
) (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [mmq_pkg::OUT_DATA_W-1:0] out_tdata
);

  localparam int SC_L = mmq_pkg::OUT_SC_LSB;
  localparam int PO_L = mmq_pkg::OUT_POS_LSB;
  localparam int MI_L = mmq_pkg::OUT_MIN_LSB;
  localparam int QC_L = mmq_pkg::OUT_QC_LSB;
  localparam int ST_L = mmq_pkg::OUT_ST_LSB;
  localparam bit NARROW = (DEPTH < 128);

  logic [mmq_pkg::STORE_COUNT_W-1:0] sc;
  logic [mmq_pkg::MIN_POS_W-1:0]     pos;
  logic [mmq_pkg::VALUE_W-1:0]       minv;
  logic [mmq_pkg::QUEUE_COUNT_W-1:0] qc;
  logic [mmq_pkg::STATUS_W-1:0]      st;

  assign sc   = out_tdata[SC_L +: mmq_pkg::STORE_COUNT_W];
  assign pos  = out_tdata[PO_L +: mmq_pkg::MIN_POS_W];
  assign minv = out_tdata[MI_L +: mmq_pkg::VALUE_W];
  assign qc   = out_tdata[QC_L +: mmq_pkg::QUEUE_COUNT_W];
  assign st   = out_tdata[ST_L +: mmq_pkg::STATUS_W];

  // A stalled result holds its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // A dequeue rejected as empty reports an empty queue and deque.
  a_empty_reject: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (st == mmq_pkg::ST_DEQ_EMPTY) |-> (qc == '0) && (sc == '0))
    else $error("empty rejection with items present");

  // An empty queue reports no minimum.
  a_empty_min: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && NARROW && (qc == '0) |-> (minv == '0) && (pos == '0))
    else $error("minimum reported for empty queue");

  // The deque never holds more entries than the queue, and the minimum lies inside it.
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && NARROW |-> (sc <= qc) && ((qc == '0) || (7'(pos) < qc)))
    else $error("deque size or minimum position out of range");

  // Requests are handled one at a time: input is closed right after a request.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("request taken while the previous one is in progress");

endmodule

bind monotonic_min_queue mmq_checker #(.DEPTH(DEPTH)) u_mmq_checker (.*);

FILE: sim/tb.sv
// Self-checking testbench for the monotonic minimum queue.
// Drives enqueue and dequeue requests, predicts every result in the bench and
// compares them field by field. Depends on mmq_pkg and monotonic_min_queue.
`timescale 1ns / 1ps

module tb;

  localparam int QDEPTH   = 64;
  localparam int SEQ_WRAP = 2 * QDEPTH;
  localparam int SC_W     = mmq_pkg::STORE_COUNT_W;
  localparam int POS_W    = mmq_pkg::MIN_POS_W;
  localparam int VAL_W    = mmq_pkg::VALUE_W;
  localparam int QC_W     = mmq_pkg::QUEUE_COUNT_W;
  localparam int ST_W     = mmq_pkg::STATUS_W;

  typedef struct {
    logic        kind;
    logic [31:0] value;
  } mmq_req_t;

  typedef struct packed {
    logic [SC_W-1:0]  store_count;
    logic [POS_W-1:0] min_position;
    logic [VAL_W-1:0] min_value;
    logic [QC_W-1:0]  queue_count;
    logic [ST_W-1:0]  status;
  } min_result_t;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           in_tvalid = 1'b0;
  logic                           in_tready;
  logic [31:0]                    in_tdata = '0;
  logic                           in_tuser = 1'b0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [mmq_pkg::OUT_DATA_W-1:0] out_tdata;

  // Requests waiting to be driven and results waiting to arrive.
  mmq_req_t    pending_reqs[$];
  min_result_t expected_results[$];

  int unsigned requests_taken = 0;
  int unsigned errors = 0;
  bit          req_taken = 1'b0;
  int unsigned hold_left = 0;
  bit          hold_done = 1'b0;

  // Mirror of the block's state: minimum deque plus queue bookkeeping.
  logic [31:0] dq_val[QDEPTH];
  int          dq_seq[QDEPTH];
  int          dq_head = 0;
  int          dq_count = 0;
  int          q_front = 0;
  int          q_items = 0;

  // Item count of the queue as seen by the stimulus generator.
  int          gen_items = 0;
  int          gen_total = 0;

  monotonic_min_queue #(.DEPTH(QDEPTH)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Applies one request to the mirrored state and returns the result it gives.
  function automatic min_result_t step_min_queue(logic kind, logic [31:0] v);
    min_result_t r;
    int          slot;
    r = '0;
    r.status = mmq_pkg::ST_OK;
    if (kind == mmq_pkg::KIND_ENQ) begin
      if (q_items >= QDEPTH) begin
        r.status = mmq_pkg::ST_ENQ_FULL;
      end else begin
        // Drop every larger entry from the back, then append.
        while (dq_count > 0 && dq_val[(dq_head + dq_count - 1) % QDEPTH] > v)
          dq_count--;
        slot = (dq_head + dq_count) % QDEPTH;
        dq_val[slot] = v;
        dq_seq[slot] = (q_front + q_items) % SEQ_WRAP;
        dq_count++;
        q_items++;
      end
    end else begin
      if (q_items == 0) begin
        r.status = mmq_pkg::ST_DEQ_EMPTY;
      end else begin
        // The deque front leaves only when it is the departing item.
        if (dq_count > 0 && dq_seq[dq_head] == q_front) begin
          dq_head = (dq_head + 1) % QDEPTH;
          dq_count--;
        end
        q_front = (q_front + 1) % SEQ_WRAP;
        q_items--;
      end
    end
    if (dq_count > 0 && q_items > 0) begin
      r.min_position = POS_W'((dq_seq[dq_head] + SEQ_WRAP - q_front) % SEQ_WRAP);
      r.min_value    = dq_val[dq_head];
    end
    r.store_count = SC_W'(dq_count);
    r.queue_count = QC_W'(q_items);
    return r;
  endfunction

  // Both sides run without idling for a stretch in the middle of the run.
  function automatic bit quiet_window();
    return requests_taken >= 1200 && requests_taken < 1500;
  endfunction

  // Queues one request and tracks the queue fill it will cause.
  task automatic push_req(logic kind, logic [31:0] v);
    mmq_req_t r;
    r.kind  = kind;
    r.value = v;
    pending_reqs.insert(pending_reqs.size(), r);
    if (kind == mmq_pkg::KIND_ENQ && gen_items < QDEPTH) gen_items++;
    if (kind == mmq_pkg::KIND_DEQ && gen_items > 0) gen_items--;
    gen_total++;
  endtask

  // Blocks until every queued request has been taken and answered.
  task automatic wait_all_done();
    while (pending_reqs.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
  endtask

  // Value shapes: random, narrow range (many equal values), rising, falling,
  // and the extremes of the range mixed with random values.
  function automatic logic [31:0] pick_value(int mode, inout logic [31:0] trend);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(7);
      2: begin
        trend = trend + $urandom_range(3);
        return trend;
      end
      3: begin
        trend = trend - $urandom_range(3);
        return trend;
      end
      default: begin
        case ($urandom_range(2))
          0: return 32'h0000_0000;
          1: return 32'hFFFF_FFFF;
          default: return $urandom;
        endcase
      end
    endcase
  endfunction

  // Request driver: a new request is presented after the last one was taken.
  always @(negedge clk) begin : req_driver
    mmq_req_t nxt;
    if (rst_n && (!in_tvalid || req_taken)) begin
      if (pending_reqs.size() != 0 && (quiet_window() || $urandom_range(99) >= 27)) begin
        nxt = pending_reqs[0];
        pending_reqs.delete(0);
        in_tvalid <= 1'b1;
        in_tuser  <= nxt.kind;
        in_tdata  <= nxt.value;
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off that fills the block.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (!hold_done && requests_taken >= 700) begin
      hold_done = 1'b1;
      hold_left = 400;
      out_tready <= 1'b0;
    end else begin
      out_tready <= quiet_window() || ($urandom_range(99) >= 27);
    end
  end

  // Monitor: checks each result, then predicts the result of each new request.
  always @(posedge clk) begin : monitor
    min_result_t got;
    min_result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        got.store_count  = out_tdata[mmq_pkg::OUT_SC_LSB  +: SC_W];
        got.min_position = out_tdata[mmq_pkg::OUT_POS_LSB +: POS_W];
        got.min_value    = out_tdata[mmq_pkg::OUT_MIN_LSB +: VAL_W];
        got.queue_count  = out_tdata[mmq_pkg::OUT_QC_LSB  +: QC_W];
        got.status       = out_tdata[mmq_pkg::OUT_ST_LSB  +: ST_W];
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected result sc=%0d pos=%0d min=%h qc=%0d st=%0d", $time,
                   got.store_count, got.min_position, got.min_value, got.queue_count,
                   got.status);
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected sc=%0d pos=%0d min=%h qc=%0d st=%0d", $time,
                     want.store_count, want.min_position, want.min_value,
                     want.queue_count, want.status);
            $display("%0t:          actual   sc=%0d pos=%0d min=%h qc=%0d st=%0d", $time,
                     got.store_count, got.min_position, got.min_value, got.queue_count,
                     got.status);
          end
        end
      end
      if (in_tvalid && in_tready) begin
        expected_results.insert(expected_results.size(),
                                step_min_queue(in_tuser, in_tdata));
        requests_taken++;
      end
      req_taken = in_tvalid && in_tready;
    end
  end

  // Stimulus: directed corner cases, then phases of fill, drain and mixed traffic.
  initial begin
    int          phase;
    int          kind_sel;
    int          mode;
    int          n;
    logic [31:0] trend;
    phase = 0;
    rst_n = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Empty dequeue, extremes, equal minima, then drain past empty.
    push_req(mmq_pkg::KIND_DEQ, 32'h5555_5555);
    push_req(mmq_pkg::KIND_ENQ, 32'hFFFF_FFFF);
    push_req(mmq_pkg::KIND_ENQ, 32'h0000_0007);
    push_req(mmq_pkg::KIND_ENQ, 32'h0000_0000);
    push_req(mmq_pkg::KIND_ENQ, 32'h0000_0000);
    push_req(mmq_pkg::KIND_ENQ, 32'h8000_0000);
    push_req(mmq_pkg::KIND_ENQ, 32'h0000_0001);
    repeat (7) push_req(mmq_pkg::KIND_DEQ, 32'hAAAA_AAAA);
    push_req(mmq_pkg::KIND_ENQ, 32'hAAAA_AAAA);
    push_req(mmq_pkg::KIND_ENQ, 32'h5555_5555);
    push_req(mmq_pkg::KIND_DEQ, 32'hFFFF_FFFF);
    push_req(mmq_pkg::KIND_DEQ, 32'h0000_0000);

    while (gen_total < 2000) begin
      // The first phases fill rising, drain, fill falling and drain.
      case (phase)
        0: begin kind_sel = 0; mode = 2; end
        1: begin kind_sel = 1; mode = 0; end
        2: begin kind_sel = 0; mode = 3; end
        3: begin kind_sel = 1; mode = 0; end
        default: begin
          kind_sel = $urandom_range(2);
          mode     = $urandom_range(4);
        end
      endcase
      trend = (mode == 3) ? ($urandom | 32'hFF00_0000) : ($urandom & 32'h00FF_FFFF);
      case (kind_sel)
        0: begin
          while (gen_items < QDEPTH) push_req(mmq_pkg::KIND_ENQ, pick_value(mode, trend));
          repeat ($urandom_range(1, 3)) push_req(mmq_pkg::KIND_ENQ, pick_value(mode, trend));
        end
        1: begin
          while (gen_items > 0) push_req(mmq_pkg::KIND_DEQ, $urandom);
          repeat ($urandom_range(1, 2)) push_req(mmq_pkg::KIND_DEQ, $urandom);
        end
        default: begin
          n = $urandom_range(20, 60);
          repeat (n) begin
            if ($urandom_range(1) == 0) push_req(mmq_pkg::KIND_ENQ, pick_value(mode, trend));
            else push_req(mmq_pkg::KIND_DEQ, $urandom);
          end
        end
      endcase
      // Now and then the sender waits for the block to go completely idle.
      if (phase == 3 || $urandom_range(7) == 0) wait_all_done();
      phase++;
    end

    wait_all_done();
    repeat (100) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
